### sv/sbse_pkg.sv
// Shared constants, codes and controller/datapath interface types for the strided byte store.
package sbse_pkg;

    localparam int CAPACITY_DEF = 4096;
    localparam int STAGE_DEF    = 64;
    localparam int REQ_LIMIT    = 64;

    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 7;
    localparam int STRIDE_W  = 8;
    localparam int OFST_W    = 12;
    localparam int CNT_W     = 7;
    localparam int NBYTES_W  = SIZE_W + CNT_W;
    localparam int BOFST_W   = SIZE_W + OFST_W;
    localparam int SKIP_W    = SIZE_W + STRIDE_W;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_READ   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_INSERT = 3'd4
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER_REQ  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAPACITY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FEW_STAGE = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_PUSH,
        OP_LATCH,
        OP_MUL,
        OP_CHECK,
        OP_ECHK,
        OP_RD_SRC,
        OP_EMIT,
        OP_JUMP,
        OP_CP_RD,
        OP_CP_WR,
        OP_SETLEN,
        OP_RD_STG,
        OP_WR_STG,
        OP_WSKIP,
        OP_SH_RD,
        OP_SH_WR,
        OP_FILL_WR,
        OP_FINAL
    } t_op;

    typedef struct packed {
        logic reject;
        logic nb_zero;
        logic elem_ok;
        logic elem_last;
        logic elem_end;
        logic fill_end;
        logic skip_zero;
        logic tail_more;
        logic shift_more;
        logic out_free;
        logic emitted;
    } t_sts;

endpackage

### sv/strided_byte_store_engine.sv
// Top level of the strided byte store engine: stream ports, sequencer and datapath.
//
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   tuser command; tdata request fields
//  m        out  o_m_tvalid/i_m_tready   tuser byte_valid; tdata result; tlast last
//
// Push writes its data byte into the staging RAM while that has room. Other commands latch
// the request, multiply and check it and, if it passes, walk the store byte by byte; every byte
// read or copied passes the store RAM's one registered read port. Remove and insert may move
// every stored byte.
// A new command is taken only once the previous one has issued its last result.
// Output stalls hold the walk at the next byte. Reset clears lengths; no clearing pass.
module strided_byte_store_engine #(
    parameter int CAPACITY    = sbse_pkg::CAPACITY_DEF,
    parameter int STAGE_BYTES = sbse_pkg::STAGE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // data_byte[7:0], element_size[14:8], stride[22:15], element_offset[34:23],
    // element_count[41:35], zero pad
    input  logic [sbse_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // command[2:0]
    input  logic [sbse_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_byte[7:0], elements_done[14:8], status[16:15], zero pad
    output logic [sbse_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // byte_valid[0]
    output logic [0:0]                         o_m_tuser,
    output logic                               o_m_tlast
);
    sbse_pkg::t_op  op;
    sbse_pkg::t_sts sts;
    logic [sbse_pkg::BYTE_W-1:0]   out_byte;
    logic                          byte_valid;
    logic [sbse_pkg::CNT_W-1:0]    elements_done;
    logic [sbse_pkg::STATUS_W-1:0] status;

    sbse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_op       (op)
    );

    sbse_dp #(.CAPACITY(CAPACITY), .STAGE_BYTES(STAGE_BYTES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_cmd            (i_s_tuser),
        .i_data_byte      (i_s_tdata[7:0]),
        .i_element_size   (i_s_tdata[14:8]),
        .i_stride         (i_s_tdata[22:15]),
        .i_element_offset (i_s_tdata[34:23]),
        .i_element_count  (i_s_tdata[41:35]),
        .o_sts            (sts),
        .o_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .o_out_byte       (out_byte),
        .o_byte_valid     (byte_valid),
        .o_elements_done  (elements_done),
        .o_status         (status),
        .o_last           (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, status, elements_done, out_byte};
    assign o_m_tuser = byte_valid;
endmodule

### sv/sbse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/sbse_ctrl.sv
// Operation sequencer: walks each command through the datapath one step per cycle while the output is free.
module sbse_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic [sbse_pkg::CMD_W-1:0] i_cmd,
    output logic                  o_s_tready,
    input  sbse_pkg::t_sts        i_sts,
    output sbse_pkg::t_op         o_op
);
    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_CHECK, S_ECHK, S_ERD, S_EOUT, S_JUMP,
        S_KCHK, S_KRD, S_KWR, S_TCHK, S_TRD, S_TWR,
        S_WRD, S_WWR, S_WSKIP, S_HCHK, S_HRD, S_HWR, S_FRD, S_FWR, S_FIN
    } t_state;

    t_state           r_state, n_state;
    sbse_pkg::t_cmd   r_cmd, n_cmd;
    logic             is_rm;

    assign is_rm      = (r_cmd == sbse_pkg::CMD_REMOVE);
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        o_op    = sbse_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_cmd == sbse_pkg::CMD_PUSH) begin
                        o_op = sbse_pkg::OP_PUSH;
                    end else if (i_cmd == sbse_pkg::CMD_READ || i_cmd == sbse_pkg::CMD_WRITE ||
                                 i_cmd == sbse_pkg::CMD_REMOVE ||
                                 i_cmd == sbse_pkg::CMD_INSERT) begin
                        o_op    = sbse_pkg::OP_LATCH;
                        n_cmd   = sbse_pkg::t_cmd'(i_cmd);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_op    = sbse_pkg::OP_MUL;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_op = sbse_pkg::OP_CHECK;
                if (i_sts.reject || i_sts.nb_zero) begin
                    n_state = S_FIN;
                end else if (r_cmd == sbse_pkg::CMD_INSERT) begin
                    n_state = S_HCHK;
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                o_op = sbse_pkg::OP_ECHK;
                if (i_sts.elem_ok) begin
                    n_state = (r_cmd == sbse_pkg::CMD_WRITE) ? S_WRD : S_ERD;
                end else begin
                    n_state = is_rm ? S_TCHK : S_FIN;
                end
            end
            S_ERD: begin
                o_op    = sbse_pkg::OP_RD_SRC;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (i_sts.out_free) begin
                    o_op = sbse_pkg::OP_EMIT;
                    if (!i_sts.elem_end) begin
                        n_state = S_ERD;
                    end else if (i_sts.elem_last) begin
                        n_state = is_rm ? S_TCHK : S_FIN;
                    end else begin
                        n_state = is_rm ? S_KCHK : S_JUMP;
                    end
                end
            end
            S_JUMP: begin
                o_op    = sbse_pkg::OP_JUMP;
                n_state = S_ECHK;
            end
            S_KCHK: begin
                n_state = i_sts.skip_zero ? S_ECHK : S_KRD;
            end
            S_KRD: begin
                o_op    = sbse_pkg::OP_CP_RD;
                n_state = S_KWR;
            end
            S_KWR: begin
                o_op    = sbse_pkg::OP_CP_WR;
                n_state = S_KCHK;
            end
            S_TCHK: begin
                if (i_sts.tail_more) begin
                    n_state = S_TRD;
                end else begin
                    o_op    = sbse_pkg::OP_SETLEN;
                    n_state = S_FIN;
                end
            end
            S_TRD: begin
                o_op    = sbse_pkg::OP_CP_RD;
                n_state = S_TWR;
            end
            S_TWR: begin
                o_op    = sbse_pkg::OP_CP_WR;
                n_state = S_TCHK;
            end
            S_WRD: begin
                o_op    = sbse_pkg::OP_RD_STG;
                n_state = S_WWR;
            end
            S_WWR: begin
                o_op    = sbse_pkg::OP_WR_STG;
                n_state = i_sts.elem_end ? S_WSKIP : S_WRD;
            end
            S_WSKIP: begin
                o_op    = sbse_pkg::OP_WSKIP;
                n_state = S_ECHK;
            end
            S_HCHK: begin
                n_state = i_sts.shift_more ? S_HRD : S_FRD;
            end
            S_HRD: begin
                o_op    = sbse_pkg::OP_SH_RD;
                n_state = S_HWR;
            end
            S_HWR: begin
                o_op    = sbse_pkg::OP_SH_WR;
                n_state = S_HCHK;
            end
            S_FRD: begin
                o_op    = sbse_pkg::OP_RD_STG;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_op    = sbse_pkg::OP_FILL_WR;
                n_state = i_sts.fill_end ? S_FIN : S_FRD;
            end
            S_FIN: begin
                if (i_sts.emitted) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_op    = sbse_pkg::OP_FINAL;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= sbse_pkg::CMD_PUSH;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end
endmodule

### sv/sbse_dp.sv
// Datapath: store and staging RAMs, walk pointers, request checks and the result register.
module sbse_dp #(
    parameter int CAPACITY    = sbse_pkg::CAPACITY_DEF,
    parameter int STAGE_BYTES = sbse_pkg::STAGE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbse_pkg::t_op                 i_op,
    input  logic [sbse_pkg::CMD_W-1:0]    i_cmd,
    input  logic [sbse_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [sbse_pkg::SIZE_W-1:0]   i_element_size,
    input  logic [sbse_pkg::STRIDE_W-1:0] i_stride,
    input  logic [sbse_pkg::OFST_W-1:0]   i_element_offset,
    input  logic [sbse_pkg::CNT_W-1:0]    i_element_count,
    output sbse_pkg::t_sts                o_sts,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [sbse_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_byte_valid,
    output logic [sbse_pkg::CNT_W-1:0]    o_elements_done,
    output logic [sbse_pkg::STATUS_W-1:0] o_status,
    output logic                          o_last
);
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int SAW = (STAGE_BYTES > 1) ? $clog2(STAGE_BYTES) : 1;
    localparam int SCW = $clog2(STAGE_BYTES + 1);
    localparam int WW  = ((LW > sbse_pkg::BOFST_W) ? LW : sbse_pkg::BOFST_W) + 2;

    sbse_pkg::t_cmd                  r_cmd;
    logic [sbse_pkg::SIZE_W-1:0]     r_size;
    logic [sbse_pkg::STRIDE_W-1:0]   r_stride;
    logic [sbse_pkg::OFST_W-1:0]     r_ofst;
    logic [sbse_pkg::CNT_W-1:0]      r_cnt;
    logic [sbse_pkg::NBYTES_W-1:0]   r_nbytes;
    logic [sbse_pkg::BOFST_W-1:0]    r_bofst;
    logic [sbse_pkg::SKIP_W-1:0]     r_skip, r_step, r_skip_left;
    logic [sbse_pkg::STATUS_W-1:0]   r_status;
    logic [LW-1:0]                   r_len, r_src, r_dst;
    logic [SCW-1:0]                  r_stage_cnt;
    logic [sbse_pkg::CNT_W-1:0]      r_got, r_idx, r_done;
    logic                            r_elem_last, r_emitted;
    logic                            r_out_valid, r_out_bvalid, r_out_last;
    logic [sbse_pkg::BYTE_W-1:0]     r_out_byte;
    logic [sbse_pkg::CNT_W-1:0]      r_out_done;
    logic [sbse_pkg::STATUS_W-1:0]   r_out_status;

    logic [sbse_pkg::STRIDE_W-1:0]   stride_eff;
    logic [WW-1:0]                   w_len, w_src, w_bofst, w_size, w_skip_end;
    logic [LW-1:0]                   pos;
    logic                            is_wr, is_ins, req_over, stage_short, cap_over;
    logic [sbse_pkg::STATUS_W-1:0]   c_status;
    logic                            elem_end, fill_end, out_free;

    logic                            st_we, st_re, sg_we, sg_re;
    logic [AW-1:0]                   st_waddr, st_raddr;
    logic [sbse_pkg::BYTE_W-1:0]     st_wdata, st_rdata, sg_rdata;
    logic [SAW-1:0]                  sg_raddr;

    assign stride_eff = (r_stride == '0) ? sbse_pkg::STRIDE_W'(1) : r_stride;
    assign w_len      = WW'(r_len);
    assign w_src      = WW'(r_src);
    assign w_bofst    = WW'(r_bofst);
    assign w_size     = WW'(r_size);
    assign w_skip_end = w_src + WW'(r_skip);
    assign pos        = (w_bofst < w_len) ? w_bofst[LW-1:0] : r_len;

    assign is_wr       = (r_cmd == sbse_pkg::CMD_WRITE);
    assign is_ins      = (r_cmd == sbse_pkg::CMD_INSERT);
    assign req_over    = r_nbytes > sbse_pkg::NBYTES_W'(sbse_pkg::REQ_LIMIT);
    assign stage_short = (is_wr || is_ins) && (r_nbytes > sbse_pkg::NBYTES_W'(r_stage_cnt));
    assign cap_over    = is_ins && ((w_len + WW'(r_nbytes)) > WW'(CAPACITY));

    always_comb begin
        if (req_over) begin
            c_status = sbse_pkg::ST_OVER_REQ;
        end else if (stage_short) begin
            c_status = sbse_pkg::ST_FEW_STAGE;
        end else if (cap_over) begin
            c_status = sbse_pkg::ST_CAPACITY;
        end else begin
            c_status = sbse_pkg::ST_OK;
        end
    end

    assign elem_end = (r_idx == r_size - sbse_pkg::SIZE_W'(1));
    assign fill_end = (sbse_pkg::NBYTES_W'(r_idx) + sbse_pkg::NBYTES_W'(1)) == r_nbytes;
    assign out_free = !r_out_valid || i_m_tready;

    assign o_sts.reject     = (c_status != sbse_pkg::ST_OK);
    assign o_sts.nb_zero    = (r_nbytes == '0);
    assign o_sts.elem_ok    = (sbse_pkg::NBYTES_W'(r_got) < r_nbytes) && (w_src + w_size <= w_len);
    assign o_sts.elem_last  = r_elem_last;
    assign o_sts.elem_end   = elem_end;
    assign o_sts.fill_end   = fill_end;
    assign o_sts.skip_zero  = (r_skip_left == '0);
    assign o_sts.tail_more  = (r_src < r_len);
    assign o_sts.shift_more = (r_dst > r_src);
    assign o_sts.out_free   = out_free;
    assign o_sts.emitted    = r_emitted;

    // store RAM port steering
    always_comb begin
        st_re    = (i_op == sbse_pkg::OP_RD_SRC) || (i_op == sbse_pkg::OP_CP_RD) ||
                   (i_op == sbse_pkg::OP_SH_RD);
        st_raddr = (i_op == sbse_pkg::OP_SH_RD) ? AW'(r_dst - LW'(1)) : AW'(r_src);
        st_we    = 1'b0;
        st_waddr = AW'(r_src);
        st_wdata = sg_rdata;
        case (i_op)
            sbse_pkg::OP_CP_WR: begin
                st_we    = 1'b1;
                st_waddr = AW'(r_dst);
                st_wdata = st_rdata;
            end
            sbse_pkg::OP_WR_STG, sbse_pkg::OP_FILL_WR: begin
                st_we = 1'b1;
            end
            sbse_pkg::OP_SH_WR: begin
                st_we    = 1'b1;
                st_waddr = AW'(WW'(r_dst) - WW'(1) + WW'(r_nbytes));
                st_wdata = st_rdata;
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    assign sg_we    = (i_op == sbse_pkg::OP_PUSH) && (r_stage_cnt < SCW'(STAGE_BYTES));
    assign sg_re    = (i_op == sbse_pkg::OP_RD_STG);
    assign sg_raddr = SAW'(r_got + r_idx);

    sbse_ram #(.WIDTH(sbse_pkg::BYTE_W), .DEPTH(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    sbse_ram #(.WIDTH(sbse_pkg::BYTE_W), .DEPTH(STAGE_BYTES)) u_stage (
        .i_clk   (i_clk),
        .i_we    (sg_we),
        .i_waddr (SAW'(r_stage_cnt)),
        .i_wdata (i_data_byte),
        .i_re    (sg_re),
        .i_raddr (sg_raddr),
        .o_rdata (sg_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_stage_cnt <= '0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == sbse_pkg::OP_EMIT || i_op == sbse_pkg::OP_FINAL) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                sbse_pkg::OP_PUSH: begin
                    if (sg_we) begin
                        r_stage_cnt <= r_stage_cnt + SCW'(1);
                    end
                end
                sbse_pkg::OP_LATCH: r_emitted <= 1'b0;
                sbse_pkg::OP_EMIT:  r_emitted <= 1'b1;
                sbse_pkg::OP_CHECK: begin
                    if (c_status == sbse_pkg::ST_OK && (is_wr || is_ins)) begin
                        r_stage_cnt <= '0;
                    end
                end
                sbse_pkg::OP_SETLEN: r_len <= r_dst;
                sbse_pkg::OP_FILL_WR: begin
                    if (fill_end) begin
                        r_len <= r_len + LW'(r_nbytes);
                    end
                end
                default: begin
                    r_len <= r_len;
                end
            endcase
        end
    end

    // walk registers and result payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            sbse_pkg::OP_LATCH: begin
                r_cmd    <= sbse_pkg::t_cmd'(i_cmd);
                r_size   <= i_element_size;
                r_stride <= i_stride;
                r_ofst   <= i_element_offset;
                r_cnt    <= i_element_count;
            end
            sbse_pkg::OP_MUL: begin
                r_nbytes <= sbse_pkg::NBYTES_W'(r_size * r_cnt);
                r_bofst  <= sbse_pkg::BOFST_W'(r_size * r_ofst);
                r_skip   <= sbse_pkg::SKIP_W'((stride_eff - sbse_pkg::STRIDE_W'(1)) * r_size);
                r_step   <= sbse_pkg::SKIP_W'(stride_eff * r_size);
            end
            sbse_pkg::OP_CHECK: begin
                r_status <= c_status;
                r_src    <= pos;
                r_dst    <= is_ins ? r_len : pos;
                r_got    <= '0;
                r_idx    <= '0;
                r_done   <= '0;
            end
            sbse_pkg::OP_ECHK: begin
                r_idx       <= '0;
                // another element follows only if it fits after this one and its skip
                r_elem_last <= !((sbse_pkg::NBYTES_W'(r_got) + sbse_pkg::NBYTES_W'(r_size)
                                  < r_nbytes) &&
                                 (w_src + WW'(r_step) + w_size <= w_len));
            end
            sbse_pkg::OP_EMIT: begin
                r_out_byte   <= st_rdata;
                r_out_bvalid <= 1'b1;
                r_out_last   <= r_elem_last && elem_end;
                r_out_done   <= (r_elem_last && elem_end) ? r_done + sbse_pkg::CNT_W'(1) : '0;
                r_out_status <= sbse_pkg::ST_OK;
                r_src        <= r_src + LW'(1);
                r_idx        <= r_idx + sbse_pkg::CNT_W'(1);
                if (elem_end) begin
                    r_got       <= r_got + r_size;
                    r_done      <= r_done + sbse_pkg::CNT_W'(1);
                    r_skip_left <= r_skip;
                end
            end
            sbse_pkg::OP_JUMP: r_src <= LW'(w_skip_end);
            sbse_pkg::OP_CP_WR: begin
                r_src <= r_src + LW'(1);
                r_dst <= r_dst + LW'(1);
                if (r_skip_left != '0) begin
                    r_skip_left <= r_skip_left - sbse_pkg::SKIP_W'(1);
                end
            end
            sbse_pkg::OP_WR_STG: begin
                r_src <= r_src + LW'(1);
                r_idx <= r_idx + sbse_pkg::CNT_W'(1);
                if (elem_end) begin
                    r_got  <= r_got + r_size;
                    r_done <= r_done + sbse_pkg::CNT_W'(1);
                end
            end
            sbse_pkg::OP_WSKIP: r_src <= (w_skip_end > w_len) ? r_len : LW'(w_skip_end);
            sbse_pkg::OP_SH_WR: r_dst <= r_dst - LW'(1);
            sbse_pkg::OP_FILL_WR: begin
                r_src <= r_src + LW'(1);
                r_idx <= r_idx + sbse_pkg::CNT_W'(1);
                if (fill_end) begin
                    r_done <= r_cnt;
                end
            end
            sbse_pkg::OP_FINAL: begin
                r_out_byte   <= '0;
                r_out_bvalid <= 1'b0;
                r_out_last   <= 1'b1;
                r_out_done   <= r_done;
                r_out_status <= r_status;
            end
            default: begin
                r_src <= r_src;
            end
        endcase
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_out_bvalid;
    assign o_elements_done = r_out_done;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;
endmodule

### sv/sbse_checker.sv
// Port-level checks on the strided byte store engine, bound to the top level.
module sbse_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [sbse_pkg::CMD_W-1:0]      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sbse_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [0:0]                      o_m_tuser,
    input logic                            o_m_tlast
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("result changed under stall");

    // a working command blocks the input for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == sbse_pkg::CMD_READ ||
         i_s_tuser == sbse_pkg::CMD_WRITE || i_s_tuser == sbse_pkg::CMD_REMOVE ||
         i_s_tuser == sbse_pkg::CMD_INSERT)) |=> !o_s_tready)
        else $error("input taken during an operation");

    // a result without a byte is always the closing one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("empty result without last");

    // an error status never comes with bytes
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[16:15] != sbse_pkg::ST_OK) |-> (!o_m_tuser[0] && o_m_tlast))
        else $error("error status on a byte result");
endmodule

bind strided_byte_store_engine sbse_checker u_sbse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
